// ===== sv/rpwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared widths and constants of the rc pulse width capture block.
// ----------------------------------------------------------------------------
package rpwc_pkg;

  // fixed field widths
  localparam int unsigned TimerWidth  = 16;
  localparam int unsigned PinWidth    = 8;
  localparam int unsigned ChanWidth   = 3;
  localparam int unsigned CountWidth  = 4;

  typedef logic [TimerWidth-1:0] timer_t;
  typedef logic [PinWidth-1:0]   pins_t;
  typedef logic [ChanWidth-1:0]  chan_t;
  typedef logic [CountWidth-1:0] count_t;

  // reset values
  localparam count_t ChanCountReset = 4'd6;
  localparam pins_t  MaskReset      = 8'h01;

endpackage

// ===== sv/rc_pulse_width_capture.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_width_capture
// Round-robin pulse width capture over the receiver channels.
// Path: an accepted item sits in the input register, and the result register
// loads its result once the result side is free to advance.
// Throughput: one item per cycle unless the result side stalls; the input
// register takes an item while a finished result waits in the output register.
// Reset: asynchronous, active low; clears all channel state, widths and
// start times, sets channel count to six and monitors channel zero.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture
  import rpwc_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  count_t      cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pins_t       pin_levels_i,
  input  timer_t      timer_count_i,
  input  chan_t       read_channel_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        width_done_o,
  output chan_t       done_channel_o,
  output timer_t      done_width_o,
  output pins_t       monitored_mask_o,
  output timer_t      read_width_o
);

  localparam int unsigned IdxWidth = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam count_t      MaxChan  = count_t'(MAX_CHANNELS);

  // configuration register
  count_t chan_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= ChanCountReset;
    end else if (cfg_we_i) begin
      chan_count_q <= cfg_wdata_i;
    end
  end

  // handshake control
  logic   s1_valid_q;
  logic   out_valid_q;
  logic   adv_out;
  logic   fire;

  assign adv_out    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv_out;
  assign fire       = s1_valid_q && adv_out;

  // input register
  pins_t  levels_q;
  timer_t timer_q;
  chan_t  rd_chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      levels_q  <= pin_levels_i;
      timer_q   <= timer_count_i;
      rd_chan_q <= read_channel_i;
    end
  end

  // channel state
  pins_t  prev_q;
  pins_t  mask_q;
  logic   armed_q;
  chan_t  cur_q;
  timer_t start_q [MAX_CHANNELS];
  timer_t width_q [MAX_CHANNELS];

  // edge detection on the monitored channel
  pins_t  seen;
  logic   rising;
  logic   falling;
  logic   done;
  timer_t done_w;
  count_t limit;
  count_t next_cnt;
  chan_t  cur_d;
  pins_t  mask_d;
  timer_t rd_w;
  logic [IdxWidth-1:0] cur_idx;
  logic [IdxWidth-1:0] rd_idx;

  assign cur_idx = cur_q[IdxWidth-1:0];
  assign rd_idx  = rd_chan_q[IdxWidth-1:0];
  assign seen    = levels_q & mask_q;
  assign rising  = |(seen & ~prev_q);
  assign falling = |(prev_q & ~seen & mask_q);
  assign done    = !rising && falling && armed_q;
  assign done_w  = timer_q - start_q[cur_idx];

  // next channel, wrapping at the smaller of the count and the channel limit
  always_comb begin
    limit    = (chan_count_q < MaxChan) ? chan_count_q : MaxChan;
    next_cnt = {1'b0, cur_q} + count_t'(1);
    if (next_cnt >= limit) begin
      cur_d = '0;
    end else begin
      cur_d = next_cnt[ChanWidth-1:0];
    end
    mask_d = pins_t'(1) << cur_d;
  end

  // width readback, seeing this item's own update
  always_comb begin
    if ({1'b0, rd_chan_q} >= MaxChan) begin
      rd_w = '0;
    end else if (done && (rd_chan_q == cur_q)) begin
      rd_w = done_w;
    end else begin
      rd_w = width_q[rd_idx];
    end
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      mask_q  <= MaskReset;
      armed_q <= 1'b0;
      cur_q   <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        start_q[i] <= '0;
        width_q[i] <= '0;
      end
    end else if (fire) begin
      prev_q <= seen;
      if (rising) begin
        start_q[cur_idx] <= timer_q;
        armed_q          <= 1'b1;
      end else if (done) begin
        width_q[cur_idx] <= done_w;
        armed_q          <= 1'b0;
        cur_q            <= cur_d;
        mask_q           <= mask_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      width_done_o     <= done;
      done_channel_o   <= done ? cur_q : '0;
      done_width_o     <= done ? done_w : '0;
      monitored_mask_o <= done ? mask_d : mask_q;
      read_width_o     <= rd_w;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mask_q))
    else $error("monitored mask is not one-hot");

  a_mask_matches_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q == (pins_t'(1) << cur_q))
    else $error("monitored mask does not match current channel");

  a_chan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cur_q} < MaxChan)
    else $error("current channel beyond channel limit");

  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !width_done_o |-> done_channel_o == '0 && done_width_o == '0)
    else $error("result without completion carries a width");

  a_done_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && done |=> !armed_q)
    else $error("capture still armed after a completed width");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the rc pulse width capture block. Pin-change items go in and
// each result item is checked against an in-bench capture predictor. Stimulus
// runs a reset check, directed edge cases, chosen channel counts, random pulse
// trains with noise under random idling, and a long stall on the result side.
// ----------------------------------------------------------------------------
module tb;
  import rpwc_pkg::*;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic   done;
    chan_t  channel;
    timer_t width;
    pins_t  mask;
    timer_t read_width;
  } capture_t;

  // block ports
  logic   clk_i          = 1'b0;
  logic   rst_ni         = 1'b0;
  logic   cfg_we_i       = 1'b0;
  count_t cfg_wdata_i    = '0;
  logic   in_valid_i     = 1'b0;
  logic   in_stall_o;
  pins_t  pin_levels_i   = '0;
  timer_t timer_count_i  = '0;
  chan_t  read_channel_i = '0;
  logic   out_valid_o;
  logic   out_stall_i    = 1'b0;
  logic   width_done_o;
  chan_t  done_channel_o;
  timer_t done_width_o;
  pins_t  monitored_mask_o;
  timer_t read_width_o;

  // capture predictor state
  pins_t  cap_prev_levels;
  timer_t cap_start [MaxChannels];
  timer_t cap_width [MaxChannels];
  logic   cap_armed;
  chan_t  cap_channel;
  pins_t  cap_mask;
  count_t cap_count;

  capture_t    expected_captures[$];
  timer_t      tick             = '0;
  int unsigned sender_idle_pct  = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned hold_request     = 0;
  int unsigned hold_left        = 0;
  int unsigned items_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned widths_completed = 0;
  int unsigned mismatches       = 0;

  rc_pulse_width_capture i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pin_levels_i     (pin_levels_i),
    .timer_count_i    (timer_count_i),
    .read_channel_i   (read_channel_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .width_done_o     (width_done_o),
    .done_channel_o   (done_channel_o),
    .done_width_o     (done_width_o),
    .monitored_mask_o (monitored_mask_o),
    .read_width_o     (read_width_o)
  );

  // clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // predictor reset state
  task automatic reset_capture_model();
    cap_prev_levels = '0;
    cap_armed       = 1'b0;
    cap_channel     = '0;
    cap_mask        = MaskReset;
    cap_count       = ChanCountReset;
    for (int i = 0; i < MaxChannels; i++) begin
      cap_start[i] = '0;
      cap_width[i] = '0;
    end
  endtask

  // expected result of one pin-change item, updates the predictor
  function automatic capture_t predict_capture(pins_t levels, timer_t stamp, chan_t rd);
    pins_t       seen;
    pins_t       rising;
    pins_t       falling;
    capture_t    res;
    int unsigned lim;
    int unsigned nxt;
    seen            = levels & cap_mask;
    rising          = (cap_prev_levels ^ seen) & seen;
    falling         = cap_prev_levels & ~seen & cap_mask;
    cap_prev_levels = seen;
    res             = '0;
    if (rising != '0) begin
      cap_start[cap_channel] = stamp;
      cap_armed              = 1'b1;
    end else if (falling != '0 && cap_armed) begin
      res.width              = stamp - cap_start[cap_channel];
      cap_width[cap_channel] = res.width;
      res.done               = 1'b1;
      res.channel            = cap_channel;
      cap_armed              = 1'b0;
      // advance, wrapping at the channel count clipped to the channel total
      lim = (cap_count < MaxChannels) ? cap_count : MaxChannels;
      nxt = cap_channel + 1;
      if (nxt >= lim) nxt = 0;
      cap_channel = chan_t'(nxt);
      cap_mask    = pins_t'(1) << cap_channel;
    end
    res.mask       = cap_mask;
    res.read_width = cap_width[rd];
    return res;
  endfunction

  // offer one item and wait until the block takes it
  task automatic send_event(pins_t levels, timer_t stamp, chan_t rd);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pin_levels_i   <= levels;
    timer_count_i  <= stamp;
    read_channel_i <= rd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_captures.push_back(predict_capture(levels, stamp, rd));
    items_sent++;
  endtask

  // random item, mostly toggling the monitored pin so pulses complete
  task automatic pulse_event(int unsigned noise_pct);
    pins_t levels;
    levels = pins_t'($urandom);
    if ($urandom_range(99) >= noise_pct) levels[cap_channel] = ~cap_prev_levels[cap_channel];
    case ($urandom_range(9))
      0:       tick = timer_t'($urandom);
      1:       ; // same timer value, zero width possible
      default: tick = tick + timer_t'($urandom_range(1, 2500));
    endcase
    send_event(levels, tick, chan_t'($urandom_range(MaxChannels - 1)));
  endtask

  // stop offering, wait for every expected result, then a drain margin
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_captures.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // channel count write, only with the block idle
  task automatic write_channel_count(count_t value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cap_count = value;
  endtask

  // result side: random stalls, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    if (mismatches < MaxReports)
      $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // compare each accepted result item with the oldest expectation
  task automatic check_capture();
    capture_t want;
    results_checked++;
    if (width_done_o) widths_completed++;
    if (expected_captures.size() == 0) begin
      note_mismatch("result with nothing pending, read_width", 0, read_width_o);
    end else begin
      want = expected_captures.pop_front();
      if (width_done_o !== want.done) note_mismatch("width_done", want.done, width_done_o);
      if (done_channel_o !== want.channel)
        note_mismatch("done_channel", want.channel, done_channel_o);
      if (done_width_o !== want.width) note_mismatch("done_width", want.width, done_width_o);
      if (monitored_mask_o !== want.mask)
        note_mismatch("monitored_mask", want.mask, monitored_mask_o);
      if (read_width_o !== want.read_width)
        note_mismatch("read_width", want.read_width, read_width_o);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_capture();
  end

  // every stored width reads zero after reset
  task automatic test_reset_state();
    for (int i = 0; i < MaxChannels; i++) send_event(8'h00, timer_t'(i), chan_t'(i));
    send_event(8'hFE, 16'h1234, 3'd7);
    settle_block();
  endtask

  // hand-picked edges on the default six-channel scan
  task automatic test_edge_cases();
    send_event(8'h01, 16'h0001, 3'd0);  // rising on channel zero
    send_event(8'hFF, 16'h0100, 3'd0);  // still high, no edge
    send_event(8'h00, 16'h0000, 3'd0);  // falling, widest width
    send_event(8'h02, 16'hFFF0, 3'd1);  // rising on channel one near the top
    send_event(8'h03, 16'hFFF8, 3'd1);  // edge on a channel no longer watched
    send_event(8'hFD, 16'h0010, 3'd1);  // falling after timer wrap
    send_event(8'hFF, 16'h4444, 3'd2);  // rising on channel two
    send_event(8'h00, 16'h4444, 3'd2);  // falling at the same time, width zero
    send_event(8'h00, 16'h5000, 3'd3);  // low and not armed, nothing happens
    send_event(8'h08, 16'hFFFF, 3'd3);  // rising at the timer maximum
    send_event(8'hF7, 16'h0FFF, 3'd3);  // falling with all other pins high
    send_event(8'h00, 16'h8000, 3'd4);
    settle_block();
  endtask

  // a set of scan lengths, including zero and past the channel total
  task automatic test_channel_counts();
    count_t counts[7] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd2, 4'd6};
    foreach (counts[k]) begin
      write_channel_count(counts[k]);
      repeat (60) pulse_event(10);
      settle_block();
    end
  endtask

  // random pulse trains under each idling mode
  task automatic test_random_traffic();
    int unsigned sender_pct[3] = '{6, 63, 0};
    int unsigned recv_pct[3]   = '{63, 6, 0};
    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = sender_pct[p];
      recv_stall_pct  = recv_pct[p];
      write_channel_count(count_t'($urandom_range(15)));
      repeat (480) pulse_event(20);
      settle_block();
    end
  endtask

  // long stall on the result side while items keep coming
  task automatic test_backpressure();
    write_channel_count(4'd8);
    hold_request = 80;
    repeat (40) pulse_event(10);
    settle_block();
  endtask

  initial begin
    reset_capture_model();
    sender_idle_pct = 6;
    recv_stall_pct  = 63;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_edge_cases();
    test_channel_counts();
    test_random_traffic();
    test_backpressure();

    $display("covered %0d items, %0d results checked, %0d completed widths",
             items_sent, results_checked, widths_completed);
    $display("channel counts 0 to 15, three idling mixes and a long result stall");
    if (mismatches == 0 && expected_captures.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
